// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of this project.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/swdr_pkg.sv =====
// Package for the stack with duplicate removal: sizes, codes and types.
// No dependencies.
package swdr_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int ENTRY_W  = 7;

  typedef logic [OP_W-1:0]         op_t;
  typedef logic [STATUS_W-1:0]     status_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ENTRY_W-1:0]      entry_t;

  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_CLEAR  = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_NODUP = 2'd3;

endpackage

// ===== sv/stack_with_duplicate_removal_core.sv =====
// Stack of signed 32-bit values with push, clear and remove-first-duplicate.
// Depends on swdr_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: operation and
//   push_value. Result channel (out_valid/out_stall) returns exactly one
//   result per request: status, removed_position, entry_count.
//   Push, clear and no-op finish in the accept cycle; the result shows up on
//   the output register in the next cycle. Remove on an empty or single-entry
//   stack also answers at once.
//   Remove on n >= 2 entries walks the store through its single read port:
//   for each candidate (position 1 downward) it fetches the candidate, then
//   compares it with the entries from the top down, one entry per cycle,
//   stopping at the first match; the gap is then closed by reading and
//   writing down each moved entry in turn, and the result is posted last.
//   One request is worked on at a time; in_stall stays high while a remove
//   runs. The output register frees the input side: a new request is taken
//   while a result waits, unless that result is stalled.
//   Reset clears the entry count and the handshake state; the store itself
//   is not cleared (only entries below the count are ever read).
//   A stalled result holds its payload until taken.
`include "assert_macros.svh"

module stack_with_duplicate_removal_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swdr_pkg::op_t     in_operation,
  input  swdr_pkg::value_t  in_push_value,
  output logic              out_valid,
  input  logic              out_stall,
  output swdr_pkg::status_t out_status,
  output swdr_pkg::pos_t    out_removed_position,
  output swdr_pkg::entry_t  out_entry_count
);
  import swdr_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_LOADP = 3'd1;  // read candidate entry
  localparam logic [2:0] S_GETP  = 3'd2;  // latch candidate, read top entry
  localparam logic [2:0] S_CMP   = 3'd3;  // compare one entry per cycle
  localparam logic [2:0] S_SHRD  = 3'd4;  // read entry above the gap
  localparam logic [2:0] S_SHWR  = 3'd5;  // write it down one place
  localparam logic [2:0] S_DONE  = 3'd6;  // post the remove result

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] ip_r, ip_nxt;    // candidate index (bottom = 0), then gap index
  logic [ADDR_W-1:0] iq_r, iq_nxt;    // index of entry whose data is in mem_rdata_r
  logic [ADDR_W-1:0] pos_r, pos_nxt;  // removed position from the top
  value_t            vp_r, vp_nxt;    // candidate value
  status_t           res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  pos_t              out_pos_r, out_pos_nxt;
  entry_t            out_count_r, out_count_nxt;

  // Store: one write port, one registered read port
  value_t            mem [DEPTH];
  value_t            mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  value_t            mem_wdata;

  logic    out_free, in_acc, out_load;
  status_t ld_status;
  pos_t    ld_pos;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ip_nxt    = ip_r;
    iq_nxt    = iq_r;
    pos_nxt   = pos_r;
    vp_nxt    = vp_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = ip_r;
    mem_wdata = mem_rdata_r;
    mem_raddr = ip_r;
    out_load  = 1'b0;
    ld_status = ST_OK;
    ld_pos    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_PUSH: begin
              out_load = 1'b1;
              if (fill_r == CNT_W'(DEPTH)) begin
                ld_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fill_r[ADDR_W-1:0];
                mem_wdata = in_push_value;
                fill_nxt  = CNT_W'(fill_r + 1'b1);
              end
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              fill_nxt = '0;
            end
            OP_REMOVE: begin
              if (fill_r == '0) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else if (fill_r == CNT_W'(1)) begin
                out_load  = 1'b1;
                ld_status = ST_NODUP;
              end else begin
                // first candidate: position 1 from the top
                ip_nxt    = ADDR_W'(fill_r - CNT_W'(2));
                state_nxt = S_LOADP;
              end
            end
            OP_NOP: begin
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_LOADP: begin
        mem_raddr = ip_r;
        iq_nxt    = ADDR_W'(fill_r - CNT_W'(1));
        state_nxt = S_GETP;
      end
      S_GETP: begin
        vp_nxt    = mem_rdata_r;
        mem_raddr = iq_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // pipelined walk: compare iq_r while fetching the one below
        mem_raddr = ADDR_W'(iq_r - 1'b1);
        iq_nxt    = ADDR_W'(iq_r - 1'b1);
        if (iq_r != ip_r && mem_rdata_r == vp_r) begin
          pos_nxt   = ADDR_W'(fill_r - CNT_W'(1) - CNT_W'(ip_r));
          state_nxt = S_SHRD;
        end else if (iq_r == '0) begin
          if (ip_r == '0) begin
            res_nxt   = ST_NODUP;
            pos_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            ip_nxt    = ADDR_W'(ip_r - 1'b1);
            state_nxt = S_LOADP;
          end
        end
      end
      S_SHRD: begin
        mem_raddr = ADDR_W'(ip_r + 1'b1);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = ip_r;
        mem_wdata = mem_rdata_r;
        if (CNT_W'(ip_r) + CNT_W'(2) == fill_r) begin
          fill_nxt  = CNT_W'(fill_r - 1'b1);
          res_nxt   = ST_OK;
          state_nxt = S_DONE;
        end else begin
          ip_nxt    = ADDR_W'(ip_r + 1'b1);
          state_nxt = S_SHRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = res_r;
          ld_pos    = POS_W'(pos_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_load || (out_valid_r && out_stall);
    out_status_nxt = out_load ? ld_status : out_status_r;
    out_pos_nxt    = out_load ? ld_pos : out_pos_r;
    out_count_nxt  = out_load ? ENTRY_W'(fill_nxt) : out_count_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ip_r         <= ip_nxt;
    iq_r         <= iq_nxt;
    pos_r        <= pos_nxt;
    vp_r         <= vp_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_removed_position = out_pos_r;
  assign out_entry_count      = out_count_r;

  // Count never passes capacity
  `ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(DEPTH))
  // A push that fits grows the count by one
  `ASSERT_NEXT(a_push_grow, clk, rst_n,
    in_acc && in_operation == OP_PUSH && fill_r != CNT_W'(DEPTH),
    fill_r == CNT_W'($past(fill_r) + 1'b1))
  // A successful remove never takes the top entry
  `ASSERT_IMPL(a_pos_nonzero, clk, rst_n, state_r == S_DONE && res_r == ST_OK, pos_r != '0)

endmodule
